FILE: src/call_frame_register_stack_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the call frame register stack
// Shared clocked assertion forms; each use expands to one labeled assertion.
// ----------------------------------------------------------------------------
`ifndef CALL_FRAME_REGISTER_STACK_TOP_MACROS_SVH
`define CALL_FRAME_REGISTER_STACK_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define CFRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked during reset.
`define CFRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/cfrs_pkg.sv
// ----------------------------------------------------------------------------
// cfrs_pkg
// Widths, command/region/status codes and sequencer states of the call frame
// register stack.
// ----------------------------------------------------------------------------
package cfrs_pkg;

	localparam int MAX_DEPTH_DEF = 16;
	localparam int MAX_REGS_DEF  = 64;

	localparam int VALUE_W  = 64;
	localparam int TAG_W    = 8;
	localparam int WORD_W   = VALUE_W + TAG_W;
	localparam int SIZE_W   = 7;
	localparam int SIZES_W  = 4 * SIZE_W;
	localparam int IDX_W    = 8;
	localparam int ID_W     = 32;
	localparam int FRAME_W  = ID_W + SIZES_W;
	localparam int DEPTH_W  = 5;
	localparam int POS_W    = IDX_W + 1;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_PUSH   = 3'd0;
	localparam cmd_t CMD_POP    = 3'd1;
	localparam cmd_t CMD_READ   = 3'd2;
	localparam cmd_t CMD_WRITE  = 3'd3;
	localparam cmd_t CMD_SETRET = 3'd4;
	localparam cmd_t CMD_INVOKE = 3'd5;

	typedef logic [1:0] region_t;
	localparam region_t REGION_ABS   = 2'd0;
	localparam region_t REGION_LOCAL = 2'd1;
	localparam region_t REGION_IN    = 2'd2;
	localparam region_t REGION_OUT   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;
	localparam status_t STATUS_RANGE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_REG,
		ST_POPID
	} state_t;

endpackage

FILE: src/cfrs_ram.sv
// ----------------------------------------------------------------------------
// cfrs_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module cfrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last word when no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/call_frame_register_stack_top.sv
// ----------------------------------------------------------------------------
// call_frame_register_stack_top
// Stack of call frames, each with a private register file split into locals,
// incoming and outgoing arguments, kept in synchronous RAMs.
// ----------------------------------------------------------------------------
// Sequence: accept issues the frame-table, mask and return-slot reads; the
//   metadata state ends most commands, while a read or a pop that leaves
//   frames behind goes on to a dependent second RAM read of register or id.
//   done is registered from the last state. No new word is taken while busy,
//   which covers the frame-table/mask read and the register-store or id read.
// Reset: arst_n clears frame count, return flags and sequencer; next id is 1.
//   No clearing pass: a push clears the frame's written mask in one write.
// The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
`include "call_frame_register_stack_top_macros.svh"

module call_frame_register_stack_top #(
	parameter int MAX_DEPTH = cfrs_pkg::MAX_DEPTH_DEF,
	parameter int MAX_REGS  = cfrs_pkg::MAX_REGS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          cmd,
	input  logic [1:0]                          region,
	input  logic [cfrs_pkg::IDX_W-1:0]          reg_index,
	input  logic signed [cfrs_pkg::VALUE_W-1:0] write_value,
	input  logic [cfrs_pkg::TAG_W-1:0]          write_tag,
	input  logic [cfrs_pkg::SIZE_W-1:0]         total_regs,
	input  logic [cfrs_pkg::SIZE_W-1:0]         in_count,
	input  logic [cfrs_pkg::SIZE_W-1:0]         out_count,
	input  logic [cfrs_pkg::SIZE_W-1:0]         local_count,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [cfrs_pkg::VALUE_W-1:0] read_value,
	output logic [cfrs_pkg::TAG_W-1:0]          read_tag,
	output logic                                ret_present,
	output logic [cfrs_pkg::DEPTH_W-1:0]        stack_depth,
	output logic [cfrs_pkg::ID_W-1:0]           top_frame_id
);

	localparam int FRAME_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int REG_AW   = $clog2(MAX_REGS);
	localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
	localparam int STORE_AW = FRAME_AW + REG_AW;
	localparam int STORE_D  = 1 << STORE_AW;
	localparam int PX_W     = cfrs_pkg::POS_W + REG_AW;

	localparam int SW = cfrs_pkg::SIZE_W;

	// ------------------------------------------------------------------
	// Control and item registers
	// ------------------------------------------------------------------
	cfrs_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]                 count_q;
	logic [cfrs_pkg::ID_W-1:0]        next_id_q;
	logic [cfrs_pkg::ID_W-1:0]        top_id_q;
	logic [MAX_DEPTH-1:0]             ret_flag_q;

	cfrs_pkg::cmd_t                   cmd_q;
	cfrs_pkg::region_t                region_q;
	logic [cfrs_pkg::IDX_W-1:0]       idx_q;
	logic [cfrs_pkg::WORD_W-1:0]      wword_q;
	logic [cfrs_pkg::SIZES_W-1:0]     sizes_q;
	logic                             hit_q;

	logic                             done_q;
	cfrs_pkg::status_t                status_q;
	logic [cfrs_pkg::WORD_W-1:0]      rword_q;
	logic                             present_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != cfrs_pkg::ST_IDLE);

	// Frame indices: top frame, next free slot, and new top after a pop.
	logic [CNT_W-1:0]    count_m1, count_m2;
	logic [FRAME_AW-1:0] top_idx, free_idx, newtop_idx;
	logic                have, full;

	assign count_m1   = count_q - CNT_W'(1);
	assign count_m2   = count_q - CNT_W'(2);
	assign top_idx    = count_m1[FRAME_AW-1:0];
	assign free_idx   = count_q[FRAME_AW-1:0];
	assign newtop_idx = count_m2[FRAME_AW-1:0];
	assign have       = (count_q != '0);
	assign full       = (count_q == CNT_W'(MAX_DEPTH));

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	// frame table: {ident, total, out, in, local}
	logic                          frame_we, frame_re;
	logic [FRAME_AW-1:0]           frame_raddr;
	logic [cfrs_pkg::FRAME_W-1:0]  frame_rd;

	logic                          mask_we;
	logic [FRAME_AW-1:0]           mask_waddr;
	logic [MAX_REGS-1:0]           mask_wd, mask_rd;

	logic                          ret_we;
	logic [cfrs_pkg::WORD_W-1:0]   ret_rd;

	logic                          store_we, store_re;
	logic [STORE_AW-1:0]           store_addr;
	logic [cfrs_pkg::WORD_W-1:0]   store_rd;

	cfrs_ram #(.WIDTH(cfrs_pkg::FRAME_W), .DEPTH(MAX_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (free_idx),
		.wdata ({next_id_q, sizes_q}),
		.re    (frame_re),
		.raddr (frame_raddr),
		.rdata (frame_rd)
	);

	cfrs_ram #(.WIDTH(MAX_REGS), .DEPTH(MAX_DEPTH)) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wd),
		.re    (accept),
		.raddr (top_idx),
		.rdata (mask_rd)
	);

	cfrs_ram #(.WIDTH(cfrs_pkg::WORD_W), .DEPTH(MAX_DEPTH)) u_ret_ram (
		.clk   (clk),
		.we    (ret_we),
		.waddr (top_idx),
		.wdata (wword_q),
		.re    (accept),
		.raddr (top_idx),
		.rdata (ret_rd)
	);

	cfrs_ram #(.WIDTH(cfrs_pkg::WORD_W), .DEPTH(STORE_D)) u_store_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_addr),
		.wdata (wword_q),
		.re    (store_re),
		.raddr (store_addr),
		.rdata (store_rd)
	);

	// ------------------------------------------------------------------
	// Register address and bounds, from the top frame's sizes
	// ------------------------------------------------------------------
	logic [SW-1:0]        local_cnt, in_cnt, total_cnt, base;
	logic [PX_W-1:0]      pos_x;
	logic [REG_AW-1:0]    pos_addr;
	logic                 pos_oor, arg_oor;

	assign local_cnt = frame_rd[SW-1:0];
	assign in_cnt    = frame_rd[2*SW-1:SW];
	assign total_cnt = frame_rd[4*SW-1:3*SW];

	always_comb begin
		case (region_q)
			cfrs_pkg::REGION_IN:  base = local_cnt;
			cfrs_pkg::REGION_OUT: base = total_cnt;
			default:              base = '0;
		endcase
		// invoke argument always lands in the incoming area
		if (cmd_q == cfrs_pkg::CMD_INVOKE) begin
			base = local_cnt;
		end
	end

	assign pos_x      = PX_W'(base) + PX_W'(idx_q);
	assign pos_addr   = pos_x[REG_AW-1:0];
	assign pos_oor    = (pos_x >= PX_W'(MAX_REGS));
	assign arg_oor    = (idx_q >= {1'b0, in_cnt}) || pos_oor;
	assign store_addr = {top_idx, pos_addr};

	// ------------------------------------------------------------------
	// Sequencer: next state, memory strobes, result
	// ------------------------------------------------------------------
	logic              res_load, res_done;
	cfrs_pkg::status_t status_d;
	logic [cfrs_pkg::WORD_W-1:0] rword_d;
	logic              present_d;
	logic              do_push, do_pop, clr_flag, set_flag, load_hit, load_id;

	always_comb begin
		state_d     = state_q;
		frame_re    = 1'b0;
		frame_raddr = top_idx;
		frame_we    = 1'b0;
		mask_we     = 1'b0;
		mask_waddr  = top_idx;
		mask_wd     = mask_rd | (MAX_REGS'(1) << pos_addr);
		ret_we      = 1'b0;
		store_we    = 1'b0;
		store_re    = 1'b0;
		res_load    = 1'b0;
		res_done    = 1'b0;
		status_d    = cfrs_pkg::STATUS_OK;
		rword_d     = '0;
		present_d   = 1'b0;
		do_push     = 1'b0;
		do_pop      = 1'b0;
		clr_flag    = 1'b0;
		set_flag    = 1'b0;
		load_hit    = 1'b0;
		load_id     = 1'b0;

		unique case (state_q)
			cfrs_pkg::ST_IDLE: begin
				// issue the top frame's metadata reads with the accept
				if (accept) begin
					frame_re = 1'b1;
					state_d  = cfrs_pkg::ST_META;
				end
			end

			cfrs_pkg::ST_META: begin
				res_load = 1'b1;
				res_done = 1'b1;
				state_d  = cfrs_pkg::ST_IDLE;
				if (cmd_q == cfrs_pkg::CMD_PUSH) begin
					if (full) begin
						status_d = cfrs_pkg::STATUS_FULL;
					end else begin
						// new frame: store sizes and id, clear its written mask
						frame_we   = 1'b1;
						mask_we    = 1'b1;
						mask_waddr = free_idx;
						mask_wd    = '0;
						do_push    = 1'b1;
					end
				end else if (cmd_q <= cfrs_pkg::CMD_INVOKE && !have) begin
					status_d = cfrs_pkg::STATUS_EMPTY;
				end else begin
					case (cmd_q)
						cfrs_pkg::CMD_POP: begin
							present_d = ret_flag_q[top_idx];
							rword_d   = ret_flag_q[top_idx] ? ret_rd : '0;
							clr_flag  = 1'b1;
							do_pop    = 1'b1;
							// fetch the id of the frame left on top
							if (count_q > CNT_W'(1)) begin
								frame_re    = 1'b1;
								frame_raddr = newtop_idx;
								res_done    = 1'b0;
								state_d     = cfrs_pkg::ST_POPID;
							end
						end
						cfrs_pkg::CMD_READ: begin
							if (pos_oor) begin
								status_d = cfrs_pkg::STATUS_RANGE;
							end else begin
								store_re = 1'b1;
								load_hit = 1'b1;
								res_load = 1'b0;
								res_done = 1'b0;
								state_d  = cfrs_pkg::ST_REG;
							end
						end
						cfrs_pkg::CMD_WRITE: begin
							if (pos_oor) begin
								status_d = cfrs_pkg::STATUS_RANGE;
							end else begin
								store_we = 1'b1;
								mask_we  = 1'b1;
							end
						end
						cfrs_pkg::CMD_SETRET: begin
							ret_we   = 1'b1;
							set_flag = 1'b1;
						end
						cfrs_pkg::CMD_INVOKE: begin
							if (arg_oor) begin
								status_d = cfrs_pkg::STATUS_RANGE;
							end else begin
								store_we = 1'b1;
								mask_we  = 1'b1;
							end
						end
						default: begin
							// unused codes: no effect, ok
						end
					endcase
				end
			end

			cfrs_pkg::ST_REG: begin
				// unwritten registers read as zero with tag zero
				res_load = 1'b1;
				res_done = 1'b1;
				rword_d  = hit_q ? store_rd : '0;
				state_d  = cfrs_pkg::ST_IDLE;
			end

			cfrs_pkg::ST_POPID: begin
				load_id  = 1'b1;
				res_done = 1'b1;
				state_d  = cfrs_pkg::ST_IDLE;
			end

			default: begin
				state_d = cfrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			next_id_q  <= cfrs_pkg::ID_W'(1);
			ret_flag_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= res_done;
			if (do_push) begin
				count_q              <= count_q + CNT_W'(1);
				next_id_q            <= next_id_q + cfrs_pkg::ID_W'(1);
				ret_flag_q[free_idx] <= 1'b0;
			end
			if (do_pop) begin
				count_q <= count_m1;
			end
			if (clr_flag) begin
				ret_flag_q[top_idx] <= 1'b0;
			end
			if (set_flag) begin
				ret_flag_q[top_idx] <= 1'b1;
			end
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			region_q <= region;
			idx_q    <= reg_index;
			wword_q  <= {write_tag, write_value};
			sizes_q  <= {total_regs, out_count, in_count, local_count};
		end
		if (load_hit) begin
			hit_q <= mask_rd[pos_addr];
		end
		if (do_push) begin
			top_id_q <= next_id_q;
		end
		if (load_id) begin
			top_id_q <= frame_rd[cfrs_pkg::FRAME_W-1:cfrs_pkg::SIZES_W];
		end
		if (res_load) begin
			status_q  <= status_d;
			rword_q   <= rword_d;
			present_q <= present_d;
		end
	end

	// ------------------------------------------------------------------
	// Result ports
	// ------------------------------------------------------------------
	assign done         = done_q;
	assign status       = status_q;
	assign read_value   = rword_q[cfrs_pkg::VALUE_W-1:0];
	assign read_tag     = rword_q[cfrs_pkg::WORD_W-1:cfrs_pkg::VALUE_W];
	assign ret_present  = present_q;
	assign stack_depth  = cfrs_pkg::DEPTH_W'(count_q);
	assign top_frame_id = have ? top_id_q : '0;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`CFRS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
	`CFRS_ASSERT_NOW(a_done_idle, done_q, state_q == cfrs_pkg::ST_IDLE, "strobe while still busy")
	`CFRS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_DEPTH), "frame count overflow")
	`CFRS_ASSERT_NOW(a_full_depth, done_q && status_q == cfrs_pkg::STATUS_FULL, full, "full status with room left")
	`CFRS_ASSERT_NOW(a_empty_id, done_q && !have, top_frame_id == '0, "empty stack shows a frame id")

endmodule
